FILE: src/ftps_pkg.sv
// Shared types, constants and helpers of the force-target position servo.
package ftps_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W = 32;
   localparam int ERR_W = 33;
   localparam int MCAND_W = 32;
   localparam int MPLR_W = 17;
   localparam int PROD_W = MCAND_W + MPLR_W;
   localparam int Q16_SHIFT = 16;

   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [16:0] NINE_TENTHS_Q16 = 17'd58982;

   localparam logic [16:0] DAMP_RESET = 17'd6554;
   localparam logic [30:0] MAX_STEP_RESET = 31'd66;
   localparam logic [15:0] INTERVAL_RESET = 16'd1;

   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET_X = 3'd0,
      REG_TARGET_Y = 3'd1,
      REG_TARGET_Z = 3'd2,
      REG_DAMPING = 3'd3,
      REG_MAX_STEP = 3'd4,
      REG_INTERVAL = 3'd5
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_AXIS,
      ST_DIV,
      ST_MUL_GO,
      ST_MUL,
      ST_SUM,
      ST_POS,
      ST_OUT
   } state_type;

   // Start strobe of a serial arithmetic unit.
   typedef struct packed {
      logic start;
   } unit_ctl_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ERR_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v[ERR_W-1] != v[ERR_W-2]) begin
         r = v[ERR_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: src/force_target_position_servo_top.sv
// Top level of the force-target position servo: sequencer, state and registers.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   step number, force, stiffness, position
//   rsp      out        rsp_valid/rsp_ready   new position and smoothed move per axis
//   csr      in         csr_write_enable      csr_index, csr_data
//
// For each item the serial divider (one bit per cycle) runs once for the refresh
// modulo and once per axis, and two serial multipliers run together once per
// axis. An axis with zero error or zero stiffness skips its division. Reset is
// synchronous and clears control and held state. A new item is accepted while
// the previous result waits in the output register; the sequencer stalls only
// at its final write if that result is still unread.
module force_target_position_servo_top #(
   parameter int FRAC_BITS = ftps_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [31:0]                            req_step_number,
   input  logic signed [31:0]                     req_force_x,
   input  logic signed [31:0]                     req_force_y,
   input  logic signed [31:0]                     req_force_z,
   input  logic signed [31:0]                     req_stiff_x,
   input  logic signed [31:0]                     req_stiff_y,
   input  logic signed [31:0]                     req_stiff_z,
   input  logic signed [31:0]                     req_pos_x,
   input  logic signed [31:0]                     req_pos_y,
   input  logic signed [31:0]                     req_pos_z,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [31:0]                     rsp_new_pos_x,
   output logic signed [31:0]                     rsp_new_pos_y,
   output logic signed [31:0]                     rsp_new_pos_z,
   output logic signed [31:0]                     rsp_move_x,
   output logic signed [31:0]                     rsp_move_y,
   output logic signed [31:0]                     rsp_move_z,
   input  logic                                   csr_write_enable,
   input  logic [ftps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [31:0]                            csr_data
);
   import ftps_pkg::*;

   localparam int NUM_W = ERR_W + FRAC_BITS;

   // Configuration.
   logic signed [DATA_W-1:0] tgt_ff [3];
   logic [16:0]              damp_ff;
   logic [30:0]              maxs_ff;
   logic [15:0]              intv_ff;

   // Item being worked on.
   logic signed [DATA_W-1:0] force_ff [3];
   logic signed [DATA_W-1:0] stiff_ff [3];
   logic signed [DATA_W-1:0] pos_ff [3];

   // Held state.
   logic signed [DATA_W-1:0] held_ff [3];
   logic signed [DATA_W-1:0] smooth_ff [3];

   // Per-axis working registers.
   state_type                state_ff, state_in;
   logic [1:0]               axis_ff;
   logic                     neg_ff;
   logic [30:0]              raw_mag_ff;
   logic signed [DATA_W-1:0] a_ff;
   logic signed [DATA_W-1:0] b_ff;
   logic signed [DATA_W-1:0] res_pos_ff [3];
   logic signed [DATA_W-1:0] res_move_ff [3];

   // Output register.
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_pos_ff [3];
   logic signed [DATA_W-1:0] rsp_move_ff [3];

   unit_ctl_type             div_ctl, mul_ctl;
   logic [NUM_W-1:0]         div_num;
   logic [DATA_W-1:0]        div_den;
   logic                     div_done;
   logic [NUM_W-1:0]         div_quot;
   logic [DATA_W-1:0]        div_rem;
   logic                     mula_done, mulb_done;
   logic [PROD_W-1:0]        prod_a, prod_b;

   logic                     req_fire;
   logic                     out_free;
   logic [15:0]              period;
   logic signed [ERR_W-1:0]  err;
   logic                     err_neg;
   logic [ERR_W-1:0]         err_mag;
   logic [DATA_W-1:0]        held_mag;
   logic [DATA_W-1:0]        smooth_mag;
   logic [16:0]              keep;
   logic [NUM_W-1:0]         q_clip;
   logic signed [ERR_W-1:0]  sum_ab;
   logic signed [DATA_W-1:0] mv;
   logic signed [ERR_W-1:0]  sum_pos;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign period = (intv_ff == 16'd0) ? 16'd1 : intv_ff;

   always_comb begin
      err = {force_ff[axis_ff][DATA_W-1], force_ff[axis_ff]}
            - {tgt_ff[axis_ff][DATA_W-1], tgt_ff[axis_ff]};
      err_neg = err[ERR_W-1];
      err_mag = err_neg ? ERR_W'(-err) : ERR_W'(err);
      held_mag = held_ff[axis_ff][DATA_W-1] ? DATA_W'(-held_ff[axis_ff])
                                            : DATA_W'(held_ff[axis_ff]);
      smooth_mag = smooth_ff[axis_ff][DATA_W-1] ? DATA_W'(-smooth_ff[axis_ff])
                                                : DATA_W'(smooth_ff[axis_ff]);
      keep = ONE_Q16 - ((damp_ff > ONE_Q16) ? ONE_Q16 : damp_ff);
      q_clip = (div_quot > NUM_W'(maxs_ff)) ? NUM_W'(maxs_ff) : div_quot;
      sum_ab = {a_ff[DATA_W-1], a_ff} + {b_ff[DATA_W-1], b_ff};
      mv = sat32(sum_ab);
      sum_pos = {pos_ff[axis_ff][DATA_W-1], pos_ff[axis_ff]}
                + {res_move_ff[axis_ff][DATA_W-1], res_move_ff[axis_ff]};
   end

   // The divider serves the refresh modulo first and then the per-axis quotients.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         div_num = NUM_W'(req_step_number);
         div_den = DATA_W'(period);
      end else begin
         div_num = {err_mag, {FRAC_BITS{1'b0}}};
         div_den = held_mag;
      end
   end

   always_comb begin
      state_in = state_ff;
      div_ctl.start = 1'b0;
      mul_ctl.start = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               div_ctl.start = 1'b1;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (div_done) begin
               state_in = ST_AXIS;
            end
         end
         ST_AXIS: begin
            if (err != '0 && held_ff[axis_ff] != '0) begin
               div_ctl.start = 1'b1;
               state_in = ST_DIV;
            end else begin
               state_in = ST_MUL_GO;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL_GO;
            end
         end
         ST_MUL_GO: begin
            mul_ctl.start = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mula_done) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_POS;
         end
         ST_POS: begin
            state_in = (axis_ff == 2'd2) ? ST_OUT : ST_AXIS;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            tgt_ff[i] <= '0;
         end
         damp_ff <= DAMP_RESET;
         maxs_ff <= MAX_STEP_RESET;
         intv_ff <= INTERVAL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TARGET_X: tgt_ff[0] <= csr_data;
            REG_TARGET_Y: tgt_ff[1] <= csr_data;
            REG_TARGET_Z: tgt_ff[2] <= csr_data;
            REG_DAMPING:  damp_ff <= csr_data[16:0];
            REG_MAX_STEP: maxs_ff <= csr_data[30:0];
            REG_INTERVAL: intv_ff <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // Held stiffness and smoothed step.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            held_ff[i] <= '0;
            smooth_ff[i] <= '0;
         end
      end else begin
         if (state_ff == ST_MOD && div_done && div_rem == '0) begin
            for (int i = 0; i < 3; i++) begin
               held_ff[i] <= stiff_ff[i];
            end
         end
         if (state_ff == ST_SUM) begin
            smooth_ff[axis_ff] <= mv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= '0;
      end else if (state_ff == ST_MOD) begin
         axis_ff <= '0;
      end else if (state_ff == ST_POS && axis_ff != 2'd2) begin
         axis_ff <= axis_ff + 1'b1;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         force_ff[0] <= req_force_x;
         force_ff[1] <= req_force_y;
         force_ff[2] <= req_force_z;
         stiff_ff[0] <= req_stiff_x;
         stiff_ff[1] <= req_stiff_y;
         stiff_ff[2] <= req_stiff_z;
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
      end
      if (state_ff == ST_AXIS) begin
         neg_ff <= err_neg;
         // Zero error gives no step; zero stiffness gives the full limit.
         raw_mag_ff <= (err == '0) ? '0 : maxs_ff;
      end
      if (state_ff == ST_DIV && div_done) begin
         raw_mag_ff <= q_clip[30:0];
      end
      if (state_ff == ST_MUL && mula_done) begin
         a_ff <= neg_ff ? -$signed(prod_a[47:16]) : $signed(prod_a[47:16]);
         b_ff <= smooth_ff[axis_ff][DATA_W-1] ? -$signed(prod_b[47:16])
                                              : $signed(prod_b[47:16]);
      end
      if (state_ff == ST_SUM) begin
         res_move_ff[axis_ff] <= mv;
      end
      if (state_ff == ST_POS) begin
         res_pos_ff[axis_ff] <= sat32(sum_pos);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         for (int i = 0; i < 3; i++) begin
            rsp_pos_ff[i] <= res_pos_ff[i];
            rsp_move_ff[i] <= res_move_ff[i];
         end
      end
   end

   ftps_div #(
      .NUM_W(NUM_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .ctl(div_ctl),
      .num(div_num),
      .den(div_den),
      .done(div_done),
      .quot(div_quot),
      .rem(div_rem)
   );

   ftps_mul u_mul_a (
      .clock(clock),
      .reset(reset),
      .ctl(mul_ctl),
      .mcand(MCAND_W'(raw_mag_ff)),
      .mplier(keep),
      .done(mula_done),
      .prod(prod_a)
   );

   ftps_mul u_mul_b (
      .clock(clock),
      .reset(reset),
      .ctl(mul_ctl),
      .mcand(smooth_mag),
      .mplier(NINE_TENTHS_Q16),
      .done(mulb_done),
      .prod(prod_b)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_new_pos_x = rsp_pos_ff[0];
   assign rsp_new_pos_y = rsp_pos_ff[1];
   assign rsp_new_pos_z = rsp_pos_ff[2];
   assign rsp_move_x = rsp_move_ff[0];
   assign rsp_move_y = rsp_move_ff[1];
   assign rsp_move_z = rsp_move_ff[2];

   a_mul_lockstep: assert property (@(posedge clock) disable iff (reset)
      mula_done == mulb_done)
      else $error("multipliers out of step");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MOD || state_ff == ST_DIV))
      else $error("divider finished outside a waiting state");

   a_accept_starts_mod: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_MOD)
      else $error("accepted item did not start the modulo");

   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff != 2'd3)
      else $error("axis index out of range");

endmodule

FILE: src/ftps_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module ftps_div #(
   parameter int NUM_W = 49
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ftps_pkg::unit_ctl_type        ctl,
   input  logic [NUM_W-1:0]              num,
   input  logic [ftps_pkg::DATA_W-1:0]   den,
   output logic                          done,
   output logic [NUM_W-1:0]              quot,
   output logic [ftps_pkg::DATA_W-1:0]   rem
);
   import ftps_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [DATA_W-1:0]  rem_ff;
   logic [DATA_W-1:0]  den_ff;

   logic [DATA_W:0]    trial;
   logic [DATA_W:0]    diff;
   logic               qbit;
   logic [DATA_W-1:0]  rem_in;
   logic [NUM_W-1:0]   num_in;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff = trial - {1'b0, den_ff};
      qbit = (trial >= {1'b0, den_ff});
      rem_in = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      num_in = {num_ff[NUM_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         num_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign rem = rem_ff;

endmodule

FILE: src/ftps_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
module ftps_mul (
   input  logic                          clock,
   input  logic                          reset,
   input  ftps_pkg::unit_ctl_type        ctl,
   input  logic [ftps_pkg::MCAND_W-1:0]  mcand,
   input  logic [ftps_pkg::MPLR_W-1:0]   mplier,
   output logic                          done,
   output logic [ftps_pkg::PROD_W-1:0]   prod
);
   import ftps_pkg::*;

   localparam int CNT_W = $clog2(MPLR_W + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [PROD_W-1:0]  mcand_ff;
   logic [PROD_W-1:0]  acc_ff;
   logic [MPLR_W-1:0]  mplier_ff;
   logic [PROD_W-1:0]  acc_in;

   assign acc_in = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MPLR_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         mcand_ff <= PROD_W'(mcand);
         mplier_ff <= mplier;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         mcand_ff <= {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[MPLR_W-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

FILE: bench/tb_force_target_position_servo_top.sv
// Testbench of the force-target position servo: random and directed steps, checked.
module tb_force_target_position_servo_top;
   import ftps_pkg::*;

   typedef struct packed {
      logic [31:0] step_number;
      logic signed [31:0] force_x, force_y, force_z;
      logic signed [31:0] stiff_x, stiff_y, stiff_z;
      logic signed [31:0] pos_x, pos_y, pos_z;
   } servo_req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
      logic signed [31:0] move_x, move_y, move_z;
   } servo_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   servo_req_type req_item = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   servo_rsp_type rsp_item;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   // Model copy of registers and state.
   logic signed [31:0] target_q[3];
   logic [16:0] damping_q;
   logic [30:0] max_step_q;
   logic [15:0] interval_q;
   logic signed [31:0] held_stiff[3];
   logic signed [31:0] smoothed_move[3];

   servo_rsp_type expected_positions[$];
   int failures = 0;
   bit hold_off = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   force_target_position_servo_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_step_number(req_item.step_number),
      .req_force_x(req_item.force_x), .req_force_y(req_item.force_y),
      .req_force_z(req_item.force_z),
      .req_stiff_x(req_item.stiff_x), .req_stiff_y(req_item.stiff_y),
      .req_stiff_z(req_item.stiff_z),
      .req_pos_x(req_item.pos_x), .req_pos_y(req_item.pos_y), .req_pos_z(req_item.pos_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_pos_x(rsp_item.new_pos_x), .rsp_new_pos_y(rsp_item.new_pos_y),
      .rsp_new_pos_z(rsp_item.new_pos_z),
      .rsp_move_x(rsp_item.move_x), .rsp_move_y(rsp_item.move_y),
      .rsp_move_z(rsp_item.move_z),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Raw step toward the target force, limited to max_step.
   function automatic logic signed [63:0] servo_raw_step(input logic signed [63:0] err,
                                                         input logic signed [31:0] stiff);
      logic [63:0] mag, den, q;
      if (err == 0) return 0;
      mag = err < 0 ? -err : err;
      if (stiff == 0) begin
         q = max_step_q;
      end else begin
         den = stiff < 0 ? -$signed({{32{stiff[31]}}, stiff}) : {32'd0, stiff};
         q = (mag << 16) / den;
         if (q > max_step_q) q = max_step_q;
      end
      return err < 0 ? -$signed(q) : $signed(q);
   endfunction

   function automatic servo_rsp_type predict_position(input servo_req_type r);
      servo_rsp_type o;
      logic [31:0] period;
      logic signed [63:0] keep, err, raw, a, b, frc, stf, pos;
      logic signed [31:0] mv, np;
      period = interval_q == 0 ? 32'd1 : {16'd0, interval_q};
      keep = 65536 - (damping_q > 17'd65536 ? 65536 : damping_q);
      if (r.step_number % period == 0) begin
         held_stiff[0] = r.stiff_x; held_stiff[1] = r.stiff_y; held_stiff[2] = r.stiff_z;
      end
      for (int i = 0; i < 3; i++) begin
         frc = i == 0 ? r.force_x : i == 1 ? r.force_y : r.force_z;
         pos = i == 0 ? r.pos_x : i == 1 ? r.pos_y : r.pos_z;
         err = frc - target_q[i];
         raw = servo_raw_step(err, held_stiff[i]);
         a = (keep * raw) / 65536;
         b = (64'sd58982 * smoothed_move[i]) / 65536;
         mv = clamp32(a + b);
         np = clamp32(pos + mv);
         smoothed_move[i] = mv;
         case (i)
            0: begin o.new_pos_x = np; o.move_x = mv; end
            1: begin o.new_pos_y = np; o.move_y = mv; end
            default: begin o.new_pos_z = np; o.move_z = mv; end
         endcase
      end
      return o;
   endfunction

   task automatic write_reg(input csr_reg_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         REG_TARGET_X: target_q[0] = value;
         REG_TARGET_Y: target_q[1] = value;
         REG_TARGET_Z: target_q[2] = value;
         REG_DAMPING: damping_q = value[16:0];
         REG_MAX_STEP: max_step_q = value[30:0];
         REG_INTERVAL: interval_q = value[15:0];
         default: begin
         end
      endcase
   endtask

   // Sends one item; inputs change at the falling edge.
   task automatic send_step(input servo_req_type r);
      req_item <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      expected_positions.push_back(predict_position(r));
      @(negedge clock);
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 150)) @(negedge clock);
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_positions.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 0;
         3: return $urandom_range(0, 2000) - 1000;
         4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic servo_req_type rand_step(input logic [31:0] step);
      servo_req_type r;
      r.step_number = step;
      r.force_x = rand_word(); r.force_y = rand_word(); r.force_z = rand_word();
      r.stiff_x = rand_word(); r.stiff_y = rand_word(); r.stiff_z = rand_word();
      r.pos_x = rand_word(); r.pos_y = rand_word(); r.pos_z = rand_word();
      return r;
   endfunction

   task automatic test_directed_extremes;
      servo_req_type r;
      logic [31:0] v[6] = '{32'h7fffffff, 32'h80000000, 0, 1, 32'hffffffff, 32'h00010000};
      for (int i = 0; i < 18; i++) begin
         r.step_number = i < 6 ? v[i] : i;
         r.force_x = v[i % 6]; r.force_y = v[(i + 1) % 6]; r.force_z = v[(i + 2) % 6];
         r.stiff_x = v[(i + 3) % 6]; r.stiff_y = v[(i / 6 + i) % 6];
         r.stiff_z = (i % 4 == 0) ? 0 : v[(i + 5) % 6];
         r.pos_x = v[(i + 2) % 6]; r.pos_y = v[(i + 4) % 6]; r.pos_z = v[(i / 3) % 6];
         send_step(r);
      end
      drain();
   endtask

   task automatic test_config_sweep;
      logic [31:0] step;
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(REG_TARGET_X, phase == 0 ? 32'h7fffffff : rand_word());
         write_reg(REG_TARGET_Y, phase == 1 ? 32'h80000000 : rand_word());
         write_reg(REG_TARGET_Z, phase == 2 ? 0 : rand_word());
         write_reg(REG_DAMPING, phase == 3 ? 0 : phase == 4 ? 65536 :
                   phase == 5 ? 32'h1ffff : $urandom_range(0, 65536));
         write_reg(REG_MAX_STEP, phase == 3 ? 32'h7fffffff : phase == 4 ? 0 :
                   phase == 6 ? 32'hffffffff : $urandom_range(0, 1 << 22));
         write_reg(REG_INTERVAL, phase == 5 ? 0 : phase == 6 ? 16'hffff :
                   phase == 7 ? 1 : $urandom_range(1, 7));
         step = $urandom;
         for (int n = 0; n < 112; n++) begin
            send_step(rand_step(step));
            step = ($urandom_range(0, 9) == 0) ? $urandom : step + 1;
         end
         drain();
      end
   endtask

   task automatic test_output_backpressure;
      hold_off = 1'b1;
      for (int n = 0; n < 40; n++) send_step(rand_step(n));
      drain();
   endtask

   // Receiver stall pattern, with a long hold-off when requested.
   initial begin
      int ph;
      ph = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end
         ph++;
         rsp_ready <= (ph % 700 < 200) ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   always @(posedge clock) begin
      servo_rsp_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_positions.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_item);
            failures++;
         end else begin
            exp_r = expected_positions.pop_front();
            if (exp_r.new_pos_x !== rsp_item.new_pos_x)
               $display("%0t new_pos_x exp %0d got %0d", $time,
                        exp_r.new_pos_x, rsp_item.new_pos_x);
            if (exp_r.new_pos_y !== rsp_item.new_pos_y)
               $display("%0t new_pos_y exp %0d got %0d", $time,
                        exp_r.new_pos_y, rsp_item.new_pos_y);
            if (exp_r.new_pos_z !== rsp_item.new_pos_z)
               $display("%0t new_pos_z exp %0d got %0d", $time,
                        exp_r.new_pos_z, rsp_item.new_pos_z);
            if (exp_r.move_x !== rsp_item.move_x)
               $display("%0t move_x exp %0d got %0d", $time, exp_r.move_x, rsp_item.move_x);
            if (exp_r.move_y !== rsp_item.move_y)
               $display("%0t move_y exp %0d got %0d", $time, exp_r.move_y, rsp_item.move_y);
            if (exp_r.move_z !== rsp_item.move_z)
               $display("%0t move_z exp %0d got %0d", $time, exp_r.move_z, rsp_item.move_z);
            if (exp_r !== rsp_item) failures++;
         end
      end
   end

   initial begin
      target_q = '{0, 0, 0};
      damping_q = DAMP_RESET;
      max_step_q = MAX_STEP_RESET;
      interval_q = INTERVAL_RESET;
      held_stiff = '{0, 0, 0};
      smoothed_move = '{0, 0, 0};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_output_backpressure();
      test_config_sweep();
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("simulation failed");
      $finish;
   end
endmodule

FILE: force_target_position_servo_top.f
src/ftps_pkg.sv
src/ftps_div.sv
src/ftps_mul.sv
src/force_target_position_servo_top.sv
bench/tb_force_target_position_servo_top.sv
